FILE: hw/rtl/gddc_pkg.sv
`default_nettype none

package gddc_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int COUNT_W = 22;

  // Signed running difference of the two serial day numbers.
  localparam int ACC_W = 25;
  typedef logic signed [ACC_W-1:0] acc_t;

  // floor(y / 100) = (y * 5243) >> 19 holds exactly for every 14-bit y.
  localparam int DIV100_MUL   = 5243;
  localparam int DIV100_SHIFT = 19;
  localparam int PROD_W       = 27;

  localparam int Q100_W = 8;
  localparam int R100_W = 7;

  localparam int DAYS_PER_YEAR = 365;
  localparam int SERIAL_W      = 23;

  localparam logic [COUNT_W-1:0] DAY_COUNT_MAX = {COUNT_W{1'b1}};

  typedef logic [8:0] doy_t;

  // Days before the first of the month; month 0 counts as January and
  // months above twelve as December.
  function automatic doy_t days_before_month(input logic [MONTH_W-1:0] m);
    doy_t res;
    case (m)
      4'd0, 4'd1: res = 9'd0;
      4'd2:       res = 9'd31;
      4'd3:       res = 9'd59;
      4'd4:       res = 9'd90;
      4'd5:       res = 9'd120;
      4'd6:       res = 9'd151;
      4'd7:       res = 9'd181;
      4'd8:       res = 9'd212;
      4'd9:       res = 9'd243;
      4'd10:      res = 9'd273;
      4'd11:      res = 9'd304;
      default:    res = 9'd334;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/gregorian_date_difference_core.sv
// Channel   Handshake              Payload
// in        start / busy           in_start_{year,month,day}, in_end_{year,month,day}
// out       out_valid (strobe)     out_day_count
// cfg       APB psel/penable/...   include_end_day at byte address 0
//
// Each date in turn passes through the reciprocal multiply for the century
// quotient (ST_MUL), the state forming the remainder (ST_REM) and five terms
// through the one shared add/subtract accumulator (ST_ACC); a last state,
// ST_DONE, clamps and saturates. The result strobe rises the cycle after that,
// with busy already low, so the next start is taken in the strobe cycle.
// Reset is synchronous and active low; it sets include_end_day to one.
// The receiver cannot stall, so each result is shown for exactly one cycle.
`default_nettype none

module gregorian_date_difference_core (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               start,
  output logic                              busy,
  input  wire  [gddc_pkg::YEAR_W-1:0]       in_start_year,
  input  wire  [gddc_pkg::MONTH_W-1:0]      in_start_month,
  input  wire  [gddc_pkg::DAY_W-1:0]        in_start_day,
  input  wire  [gddc_pkg::YEAR_W-1:0]       in_end_year,
  input  wire  [gddc_pkg::MONTH_W-1:0]      in_end_month,
  input  wire  [gddc_pkg::DAY_W-1:0]        in_end_day,
  output logic                              out_valid,
  output logic [gddc_pkg::COUNT_W-1:0]      out_day_count,
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [2:0]                        paddr,
  input  wire  [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import gddc_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_REM  = 3'd2;
  localparam logic [2:0] ST_ACC  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  localparam logic [2:0] TERM_YEARS = 3'd0;
  localparam logic [2:0] TERM_DIV4  = 3'd1;
  localparam logic [2:0] TERM_DIV100 = 3'd2;
  localparam logic [2:0] TERM_DIV400 = 3'd3;
  localparam logic [2:0] TERM_DOY   = 3'd4;

  logic [2:0]             state_r, state_nxt;
  logic [2:0]             term_r, term_nxt;
  logic                   sel_r, sel_nxt;
  acc_t                   acc_r, acc_nxt;
  logic [Q100_W-1:0]      q_r, q_nxt;
  logic [R100_W-1:0]      rem_r, rem_nxt;
  logic                   inc_r;
  logic                   out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0]     count_r, count_nxt;

  logic [YEAR_W-1:0]      sy_r, ey_r;
  logic [MONTH_W-1:0]     sm_r, em_r;
  logic [DAY_W-1:0]       sd_r, ed_r;

  logic [YEAR_W-1:0]      y;
  logic [MONTH_W-1:0]     m;
  logic [DAY_W-1:0]       d;
  logic [PROD_W-1:0]      prod;
  logic                   leap;
  logic                   rem_nz;
  logic [SERIAL_W-1:0]    term;
  logic                   neg;
  logic [ACC_W-1:0]       diff;
  logic [ACC_W-1:0]       total;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = {31'd0, inc_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inc_r <= 1'b1;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      inc_r <= pwdata[0];
    end
  end

  // Operand selection for the date being worked on
  assign y = sel_r ? ey_r : sy_r;
  assign m = sel_r ? em_r : sm_r;
  assign d = sel_r ? ed_r : sd_r;

  assign prod   = PROD_W'(y) * PROD_W'(DIV100_MUL);
  assign rem_nz = (rem_r != '0);
  assign leap   = rem_nz ? (y[1:0] == 2'd0) : (q_r[1:0] == 2'd0);

  always_comb begin
    case (term_r)
      TERM_YEARS:  term = SERIAL_W'(y) * SERIAL_W'(DAYS_PER_YEAR);
      TERM_DIV4:   term = SERIAL_W'((YEAR_W+1)'(y) + (YEAR_W+1)'(3)) >> 2;
      TERM_DIV100: term = SERIAL_W'(q_r) + SERIAL_W'(rem_nz);
      TERM_DIV400: term = SERIAL_W'(q_r >> 2)
                          + SERIAL_W'(rem_nz || (q_r[1:0] != 2'd0));
      TERM_DOY:    term = SERIAL_W'(days_before_month(m)) + SERIAL_W'(d)
                          + SERIAL_W'(leap && (m > 4'd2));
      default:     term = '0;
    endcase
  end

  // The start date's serial number is subtracted, the end date's added.
  assign neg  = !sel_r ^ (term_r == TERM_DIV100);
  assign diff = (acc_r > 0) ? acc_r : '0;
  assign total = diff + ACC_W'(inc_r);

  always_comb begin
    state_nxt     = state_r;
    term_nxt      = term_r;
    sel_nxt       = sel_r;
    acc_nxt       = acc_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    out_valid_nxt = 1'b0;
    count_nxt     = count_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_MUL;
          sel_nxt   = 1'b0;
          acc_nxt   = '0;
        end
      end
      ST_MUL: begin
        q_nxt     = Q100_W'(prod >> DIV100_SHIFT);
        state_nxt = ST_REM;
      end
      ST_REM: begin
        rem_nxt   = R100_W'(y - YEAR_W'(q_r) * YEAR_W'(100));
        term_nxt  = TERM_YEARS;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        acc_nxt = neg ? (acc_r - acc_t'(term)) : (acc_r + acc_t'(term));
        if (term_r == TERM_DOY) begin
          if (sel_r) begin
            state_nxt = ST_DONE;
          end else begin
            sel_nxt   = 1'b1;
            state_nxt = ST_MUL;
          end
        end else begin
          term_nxt = term_r + 3'd1;
        end
      end
      ST_DONE: begin
        count_nxt     = (total > ACC_W'(DAY_COUNT_MAX)) ? DAY_COUNT_MAX
                                                        : COUNT_W'(total);
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    term_r  <= term_nxt;
    sel_r   <= sel_nxt;
    acc_r   <= acc_nxt;
    q_r     <= q_nxt;
    rem_r   <= rem_nxt;
    count_r <= count_nxt;
    if (start && !busy) begin
      sy_r <= in_start_year;
      sm_r <= in_start_month;
      sd_r <= in_start_day;
      ey_r <= in_end_year;
      em_r <= in_end_month;
      ed_r <= in_end_day;
    end
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_day_count = count_r;

endmodule

`default_nettype wire

FILE: hw/rtl/gddc_checker.sv
`default_nettype none

module gddc_checker (
  input wire clk,
  input wire rst_n,
  input wire start,
  input wire busy,
  input wire out_valid
);

  // An accepted beat makes the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("block not busy after an accepted beat");

  // The result strobe lasts a single cycle.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // The block leaves busy exactly when it presents its result.
  a_fell_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(busy))
    else $error("result strobe outside the end of a computation");

endmodule

bind gregorian_date_difference_core gddc_checker u_gddc_checker (.*);

`default_nettype wire
